/* sv/obbsat_pkg.sv */
// Shared widths, types and helpers of the box pair overlap test.
package obbsat_pkg;

	localparam int CW    = 32;
	localparam int FB    = 16;
	localparam int NSLOT = 10;
	localparam int NAX   = 15;
	localparam int NFACE = 3;
	localparam int NCRN  = 8;

	localparam int SL_AX   = 1;
	localparam int SL_SIZE = 4;
	localparam int SL_B    = 5;

	localparam int HW   = 2 * CW - FB;
	localparam int KW   = HW + 2;
	localparam int CRW  = HW + 1;
	localparam int MW   = KW;
	localparam int DG   = 13;
	localparam int ND   = (MW + DG - 1) / DG;
	localparam int MWP  = ND * DG;
	localparam int PW   = MW + MWP;
	localparam int DW   = 2 * MW - FB;
	localparam int DOTW = DW + 2;
	localparam int CMPW = DOTW + 2;
	localparam int CNTW = (ND > 1) ? $clog2(ND) : 1;

	typedef struct packed {
		logic                 we;
		logic [3:0]           slot;
		logic signed [CW-1:0] vx;
		logic signed [CW-1:0] vy;
		logic signed [CW-1:0] vz;
		logic                 last;
	} beat_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_HALF,
		B_CROSS,
		B_PROJ,
		B_CMP,
		B_DONE
	} bst_t;

	function automatic logic [1:0] nxt1(input logic [1:0] c);
		logic [1:0] r;
		case (c)
			2'd0: r = 2'd1;
			2'd1: r = 2'd2;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] nxt2(input logic [1:0] c);
		logic [1:0] r;
		case (c)
			2'd0: r = 2'd2;
			2'd1: r = 2'd0;
			default: r = 2'd1;
		endcase
		return r;
	endfunction

endpackage

/* sv/obbsat_front.sv */
// Input stage: accept beats, classify the slot, register the coordinates.
module obbsat_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [3:0]             slot,
	input  logic signed [31:0]     vx,
	input  logic signed [31:0]     vy,
	input  logic signed [31:0]     vz,
	input  logic                   last,
	output obbsat_pkg::beat_t      beat,
	output logic                   beat_vld,
	input  logic                   beat_rdy
);

	obbsat_pkg::beat_t beat_q;
	logic              vld_q;

	assign in_ready = !vld_q || beat_rdy;
	assign beat     = beat_q;
	assign beat_vld = vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			beat_q.we   <= (slot < 4'(obbsat_pkg::NSLOT));
			beat_q.slot <= slot;
			beat_q.vx   <= obbsat_pkg::CW'(vx);
			beat_q.vy   <= obbsat_pkg::CW'(vy);
			beat_q.vz   <= obbsat_pkg::CW'(vz);
			beat_q.last <= last;
		end
	end

endmodule

/* sv/obbsat_fifo.sv */
// Two-entry beat queue between the front and the back.
module obbsat_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  obbsat_pkg::beat_t wr_beat,
	input  logic              wr_vld,
	output logic              wr_rdy,
	output obbsat_pkg::beat_t rd_beat,
	output logic              rd_vld,
	input  logic              rd_rdy
);

	obbsat_pkg::beat_t mem_q [2];
	logic              wp_q;
	logic              rp_q;
	logic [1:0]        cnt_q;
	logic              push;
	logic              pop;

	assign wr_rdy  = (cnt_q != 2'd2);
	assign rd_vld  = (cnt_q != 2'd0);
	assign rd_beat = mem_q[rp_q];
	assign push    = wr_vld && wr_rdy;
	assign pop     = rd_vld && rd_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop)  rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_beat;
	end

endmodule

/* sv/obbsat_mul.sv */
// Multi-cycle signed fixed-point multiplier, one digit of the multiplier per cycle.
module obbsat_mul (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic signed [obbsat_pkg::MW-1:0]  a,
	input  logic signed [obbsat_pkg::MW-1:0]  b,
	output logic                              done,
	output logic signed [obbsat_pkg::DW-1:0]  res
);

	logic [obbsat_pkg::MW-1:0]          am;
	logic [obbsat_pkg::MW-1:0]          bm;
	logic [obbsat_pkg::MW-1:0]          amag_q;
	logic [obbsat_pkg::MWP-1:0]         bmag_q;
	logic                               neg_q;
	logic [obbsat_pkg::PW-1:0]          acc_q;
	logic [obbsat_pkg::CNTW-1:0]        cnt_q;
	logic                               run_q;
	logic                               fin_q;
	logic                               done_q;
	logic signed [obbsat_pkg::DW-1:0]   res_q;
	logic [obbsat_pkg::DG-1:0]          dig;
	logic [obbsat_pkg::MW+obbsat_pkg::DG-1:0] pp;
	logic signed [obbsat_pkg::PW-1:0]   sp;

	assign am   = a[obbsat_pkg::MW-1] ? -a : a;
	assign bm   = b[obbsat_pkg::MW-1] ? -b : b;
	assign dig  = bmag_q[cnt_q*obbsat_pkg::DG +: obbsat_pkg::DG];
	assign pp   = amag_q * dig;
	assign sp   = neg_q ? -acc_q : acc_q;
	assign done = done_q;
	assign res  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == obbsat_pkg::CNTW'(obbsat_pkg::ND - 1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			amag_q <= am;
			bmag_q <= obbsat_pkg::MWP'(bm);
			neg_q  <= a[obbsat_pkg::MW-1] ^ b[obbsat_pkg::MW-1];
			acc_q  <= '0;
		end else if (run_q) begin
			acc_q <= acc_q + (obbsat_pkg::PW'(pp) << (cnt_q * obbsat_pkg::DG));
		end
		if (fin_q) res_q <= obbsat_pkg::DW'(sp >>> obbsat_pkg::FB);
	end

endmodule

/* sv/obbsat_back.sv */
// Back end: vector store, half vectors, cross axes, projections and the overlap verdict.
module obbsat_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  obbsat_pkg::beat_t                 q_beat,
	input  logic                              q_vld,
	output logic                              q_rdy,
	output logic                              mul_start,
	output logic signed [obbsat_pkg::MW-1:0]  mul_a,
	output logic signed [obbsat_pkg::MW-1:0]  mul_b,
	input  logic                              mul_done,
	input  logic signed [obbsat_pkg::DW-1:0]  mul_res,
	output logic                              out_valid,
	output logic                              hit,
	input  logic                              out_ready
);

	obbsat_pkg::bst_t state_q, state_d;

	logic signed [obbsat_pkg::CW-1:0]   vst_q   [obbsat_pkg::NSLOT][3];
	logic signed [obbsat_pkg::HW-1:0]   half_q  [2][3][3];
	logic signed [obbsat_pkg::CRW-1:0]  cross_q [9][3];
	logic signed [obbsat_pkg::DW-1:0]   tmp_q;
	logic signed [obbsat_pkg::DOTW-1:0] dot_q;
	logic signed [obbsat_pkg::DOTW-1:0] mn_q [2];
	logic signed [obbsat_pkg::DOTW-1:0] mx_q [2];

	logic       pend_q;
	logic       b_q;
	logic [1:0] i_q;
	logic [1:0] j_q;
	logic [1:0] k_q;
	logic [1:0] c_q;
	logic       t_q;
	logic [2:0] n_q;
	logic [3:0] ax_q;
	logic       hit_q;
	logic       out_vld_q;
	logic       out_hit_q;

	logic       half_end;
	logic       cross_end;
	logic       box_end;
	logic       out_free;
	logic [3:0] sbase;
	logic [3:0] cidx;
	logic signed [obbsat_pkg::KW-1:0]   crn;
	logic signed [obbsat_pkg::MW-1:0]   axc;
	logic signed [obbsat_pkg::DOTW-1:0] dsum;
	logic signed [obbsat_pkg::DOTW-1:0] hi;
	logic signed [obbsat_pkg::DOTW-1:0] lo;
	logic signed [obbsat_pkg::CMPW-1:0] span_sum;
	logic signed [obbsat_pkg::CMPW-1:0] span_all;

	assign half_end  = b_q && (i_q == 2'd2) && (k_q == 2'd2);
	assign cross_end = t_q && (c_q == 2'd2) && (j_q == 2'd2) && (i_q == 2'd2);
	assign box_end   = b_q && (k_q == 2'd2) && (n_q == 3'(obbsat_pkg::NCRN - 1));
	assign out_free  = !out_vld_q || out_ready;
	assign sbase     = b_q ? 4'(obbsat_pkg::SL_B) : 4'd0;
	assign cidx      = {1'b0, i_q, 1'b0} + {2'b00, i_q} + {2'b00, j_q};
	assign dsum      = dot_q + obbsat_pkg::DOTW'(mul_res);
	assign out_valid = out_vld_q;
	assign hit       = out_hit_q;

	assign hi       = (mx_q[0] < mx_q[1]) ? mx_q[1] : mx_q[0];
	assign lo       = (mn_q[1] < mn_q[0]) ? mn_q[1] : mn_q[0];
	assign span_sum = obbsat_pkg::CMPW'(mx_q[0]) - obbsat_pkg::CMPW'(mn_q[0])
	                + obbsat_pkg::CMPW'(mx_q[1]) - obbsat_pkg::CMPW'(mn_q[1]);
	assign span_all = obbsat_pkg::CMPW'(hi) - obbsat_pkg::CMPW'(lo);

	always_comb begin
		crn = obbsat_pkg::KW'(vst_q[sbase][k_q]);
		for (int ii = 0; ii < 3; ii++) begin
			if (n_q[2-ii]) crn = crn - obbsat_pkg::KW'(half_q[b_q][ii][k_q]);
			else           crn = crn + obbsat_pkg::KW'(half_q[b_q][ii][k_q]);
		end
	end

	always_comb begin
		if (ax_q < 4'(obbsat_pkg::NFACE)) begin
			axc = obbsat_pkg::MW'(vst_q[4'(obbsat_pkg::SL_AX) + ax_q][k_q]);
		end else if (ax_q < 4'(2 * obbsat_pkg::NFACE)) begin
			axc = obbsat_pkg::MW'(vst_q[ax_q + 4'(obbsat_pkg::SL_B + obbsat_pkg::SL_AX
			      - obbsat_pkg::NFACE)][k_q]);
		end else begin
			axc = obbsat_pkg::MW'(cross_q[ax_q - 4'(2 * obbsat_pkg::NFACE)][k_q]);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			obbsat_pkg::B_IDLE:  if (q_vld && q_beat.last) state_d = obbsat_pkg::B_HALF;
			obbsat_pkg::B_HALF:  if (mul_done && half_end) state_d = obbsat_pkg::B_CROSS;
			obbsat_pkg::B_CROSS: if (mul_done && cross_end) state_d = obbsat_pkg::B_PROJ;
			obbsat_pkg::B_PROJ:  if (mul_done && box_end) state_d = obbsat_pkg::B_CMP;
			obbsat_pkg::B_CMP: begin
				if (ax_q == 4'(obbsat_pkg::NAX - 1)) state_d = obbsat_pkg::B_DONE;
				else                                 state_d = obbsat_pkg::B_PROJ;
			end
			obbsat_pkg::B_DONE:  if (out_free) state_d = obbsat_pkg::B_IDLE;
			default:             state_d = obbsat_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		q_rdy     = 1'b0;
		mul_start = 1'b0;
		mul_a     = crn;
		mul_b     = axc;
		case (state_q)
			obbsat_pkg::B_IDLE: q_rdy = 1'b1;
			obbsat_pkg::B_HALF: begin
				mul_start = !pend_q;
				mul_a = obbsat_pkg::MW'(vst_q[sbase + 4'(obbsat_pkg::SL_AX) + {2'b00, i_q}][k_q]);
				mul_b = obbsat_pkg::MW'(vst_q[sbase + 4'(obbsat_pkg::SL_SIZE)][i_q]);
			end
			obbsat_pkg::B_CROSS: begin
				mul_start = !pend_q;
				if (!t_q) begin
					mul_a = obbsat_pkg::MW'(vst_q[4'(obbsat_pkg::SL_AX) + {2'b00, i_q}]
					        [obbsat_pkg::nxt1(c_q)]);
					mul_b = obbsat_pkg::MW'(vst_q[4'(obbsat_pkg::SL_B + obbsat_pkg::SL_AX)
					        + {2'b00, j_q}][obbsat_pkg::nxt2(c_q)]);
				end else begin
					mul_a = obbsat_pkg::MW'(vst_q[4'(obbsat_pkg::SL_AX) + {2'b00, i_q}]
					        [obbsat_pkg::nxt2(c_q)]);
					mul_b = obbsat_pkg::MW'(vst_q[4'(obbsat_pkg::SL_B + obbsat_pkg::SL_AX)
					        + {2'b00, j_q}][obbsat_pkg::nxt1(c_q)]);
				end
			end
			obbsat_pkg::B_PROJ: mul_start = !pend_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= obbsat_pkg::B_IDLE;
			pend_q    <= 1'b0;
			b_q       <= 1'b0;
			i_q       <= 2'd0;
			j_q       <= 2'd0;
			k_q       <= 2'd0;
			c_q       <= 2'd0;
			t_q       <= 1'b0;
			n_q       <= 3'd0;
			ax_q      <= 4'd0;
			hit_q     <= 1'b1;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mul_start) pend_q <= 1'b1;
			else if (mul_done) pend_q <= 1'b0;
			if (state_q == obbsat_pkg::B_DONE && out_free) out_vld_q <= 1'b1;
			else if (out_ready)                            out_vld_q <= 1'b0;
			case (state_q)
				obbsat_pkg::B_IDLE: begin
					if (q_vld && q_beat.last) begin
						hit_q <= 1'b1;
						ax_q  <= 4'd0;
					end
				end
				obbsat_pkg::B_HALF: begin
					if (mul_done) begin
						k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
						if (k_q == 2'd2) begin
							i_q <= (i_q == 2'd2) ? 2'd0 : i_q + 2'd1;
							if (i_q == 2'd2) b_q <= !b_q;
						end
					end
				end
				obbsat_pkg::B_CROSS: begin
					if (mul_done) begin
						t_q <= !t_q;
						if (t_q) begin
							c_q <= (c_q == 2'd2) ? 2'd0 : c_q + 2'd1;
							if (c_q == 2'd2) begin
								j_q <= (j_q == 2'd2) ? 2'd0 : j_q + 2'd1;
								if (j_q == 2'd2) i_q <= (i_q == 2'd2) ? 2'd0 : i_q + 2'd1;
							end
						end
					end
				end
				obbsat_pkg::B_PROJ: begin
					if (mul_done) begin
						k_q <= (k_q == 2'd2) ? 2'd0 : k_q + 2'd1;
						if (k_q == 2'd2) begin
							n_q <= n_q + 3'd1;
							if (n_q == 3'(obbsat_pkg::NCRN - 1)) b_q <= !b_q;
						end
					end
				end
				obbsat_pkg::B_CMP: begin
					if (span_sum < span_all) hit_q <= 1'b0;
					ax_q <= ax_q + 4'd1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == obbsat_pkg::B_IDLE && q_vld && q_beat.we) begin
			vst_q[q_beat.slot][0] <= q_beat.vx;
			vst_q[q_beat.slot][1] <= q_beat.vy;
			vst_q[q_beat.slot][2] <= q_beat.vz;
		end
		if (state_q == obbsat_pkg::B_IDLE) dot_q <= '0;
		if (state_q == obbsat_pkg::B_HALF && mul_done) begin
			half_q[b_q][i_q][k_q] <= obbsat_pkg::HW'(mul_res);
		end
		if (state_q == obbsat_pkg::B_CROSS && mul_done) begin
			if (!t_q) tmp_q <= mul_res;
			else      cross_q[cidx][c_q] <= obbsat_pkg::CRW'(tmp_q - mul_res);
		end
		if (state_q == obbsat_pkg::B_PROJ && mul_done) begin
			if (k_q != 2'd2) begin
				dot_q <= dsum;
			end else begin
				dot_q <= '0;
				if (n_q == 3'd0) begin
					mn_q[b_q] <= dsum;
					mx_q[b_q] <= dsum;
				end else begin
					if (dsum < mn_q[b_q]) mn_q[b_q] <= dsum;
					if (mx_q[b_q] < dsum) mx_q[b_q] <= dsum;
				end
			end
		end
		if (state_q == obbsat_pkg::B_DONE && out_free) out_hit_q <= hit_q;
	end

endmodule

/* sv/obb_pair_separating_axis_test_top.sv */
// Top level of the oriented box pair separating axis overlap test.
// Load beats are taken one per cycle while the back end is idle; the queue absorbs three more.
// A beat with last set starts the test: 792 products through the one multi-cycle multiplier,
// plus a compare step for each axis, after which hit is presented.
// Reset clears the queue, the sequencer and the output; the vector store is undefined until written.
module obb_pair_separating_axis_test_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [3:0]         slot,
	input  logic signed [31:0] vx,
	input  logic signed [31:0] vy,
	input  logic signed [31:0] vz,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               hit
);

	obbsat_pkg::beat_t                f_beat;
	logic                             f_vld;
	logic                             f_rdy;
	obbsat_pkg::beat_t                q_beat;
	logic                             q_vld;
	logic                             q_rdy;
	logic                             mul_start;
	logic signed [obbsat_pkg::MW-1:0] mul_a;
	logic signed [obbsat_pkg::MW-1:0] mul_b;
	logic                             mul_done;
	logic signed [obbsat_pkg::DW-1:0] mul_res;

	obbsat_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.slot     (slot),
		.vx       (vx),
		.vy       (vy),
		.vz       (vz),
		.last     (last),
		.beat     (f_beat),
		.beat_vld (f_vld),
		.beat_rdy (f_rdy)
	);

	obbsat_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_beat (f_beat),
		.wr_vld  (f_vld),
		.wr_rdy  (f_rdy),
		.rd_beat (q_beat),
		.rd_vld  (q_vld),
		.rd_rdy  (q_rdy)
	);

	obbsat_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.res    (mul_res)
	);

	obbsat_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_beat    (q_beat),
		.q_vld     (q_vld),
		.q_rdy     (q_rdy),
		.mul_start (mul_start),
		.mul_a     (mul_a),
		.mul_b     (mul_b),
		.mul_done  (mul_done),
		.mul_res   (mul_res),
		.out_valid (out_valid),
		.hit       (hit),
		.out_ready (out_ready)
	);

endmodule

/* sv/obbsat_chk.sv */
// Port-level checker of the overlap test, bound to the top level.
module obbsat_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic [3:0]         slot,
	input logic signed [31:0] vx,
	input logic signed [31:0] vy,
	input logic signed [31:0] vz,
	input logic               last,
	input logic               out_valid,
	input logic               out_ready,
	input logic               hit
);

	localparam logic [3:0] MaxOut = 4'd5;

	logic [3:0] pend_q;
	logic       last_beat;
	logic       out_beat;

	assign last_beat = in_valid && in_ready && last;
	assign out_beat  = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 4'd0;
		end else begin
			pend_q <= pend_q + 4'(last_beat) - 4'(out_beat);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hit))
		else $error("result dropped or changed while stalled");

	a_out_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("result withdrawn without a beat");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 4'd0)
		else $error("result without a last beat");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= MaxOut)
		else $error("more tests in flight than the datapath holds");

endmodule

bind obb_pair_separating_axis_test_top obbsat_chk u_chk (.*);

/* dv/testbench.sv */
// Testbench for the oriented box pair overlap test: directed and random box pairs checked against a predictor.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ONE       = 65536;
	localparam int N_ITEMS   = 900;
	localparam int CALM_LEFT = 60;
	localparam int LIMIT     = 20000000;

	typedef logic signed [255:0] wd_t;

	typedef struct {
		logic [3:0]         slot;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic               last;
	} load_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [3:0]         slot;
	logic signed [31:0] vx;
	logic signed [31:0] vy;
	logic signed [31:0] vz;
	logic               last;
	logic               out_valid;
	logic               out_ready;
	logic               hit;

	load_t              loads[$];
	bit                 hits_due[$];
	logic signed [31:0] vec_mem[30];
	load_t              cur;
	int                 n_loaded;
	int                 errors;
	int                 in_gap;
	int                 out_gap;
	int                 cycles;

	obb_pair_separating_axis_test_top u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.slot(slot), .vx(vx), .vy(vy), .vz(vz), .last(last),
		.out_valid(out_valid), .out_ready(out_ready), .hit(hit)
	);

	always #4 clk = ~clk;

	function automatic wd_t mq(wd_t a, wd_t b);
		wd_t p;
		p = a * b;
		return p >>> obbsat_pkg::FB;
	endfunction

	function automatic wd_t dot(wd_t p0, wd_t p1, wd_t p2, wd_t q0, wd_t q1, wd_t q2);
		return mq(p0, q0) + mq(p1, q1) + mq(p2, q2);
	endfunction

	function automatic bit boxes_overlap();
		wd_t a[3][3], b[3][3], ha[3][3], hb[3][3], ca[8][3], cb[8][3], ax[15][3];
		wd_t mna, mxa, mnb, mxb, d, sum, span;
		bit  ov;
		ov = 1;
		for (int i = 0; i < 3; i++)
			for (int k = 0; k < 3; k++) begin
				a[i][k]  = vec_mem[(1 + i) * 3 + k];
				b[i][k]  = vec_mem[(6 + i) * 3 + k];
				ha[i][k] = mq(a[i][k], wd_t'(vec_mem[12 + i]));
				hb[i][k] = mq(b[i][k], wd_t'(vec_mem[27 + i]));
			end
		for (int n = 0; n < 8; n++)
			for (int k = 0; k < 3; k++) begin
				ca[n][k] = vec_mem[k];
				cb[n][k] = vec_mem[15 + k];
				for (int i = 0; i < 3; i++) begin
					if ((n >> (2 - i)) & 1) begin
						ca[n][k] = ca[n][k] - ha[i][k];
						cb[n][k] = cb[n][k] - hb[i][k];
					end else begin
						ca[n][k] = ca[n][k] + ha[i][k];
						cb[n][k] = cb[n][k] + hb[i][k];
					end
				end
			end
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++) begin
				ax[i][k]     = a[i][k];
				ax[3 + i][k] = b[i][k];
			end
			for (int j = 0; j < 3; j++) begin
				ax[6 + i * 3 + j][0] = mq(a[i][1], b[j][2]) - mq(a[i][2], b[j][1]);
				ax[6 + i * 3 + j][1] = mq(a[i][2], b[j][0]) - mq(a[i][0], b[j][2]);
				ax[6 + i * 3 + j][2] = mq(a[i][0], b[j][1]) - mq(a[i][1], b[j][0]);
			end
		end
		for (int s = 0; s < 15; s++) begin
			for (int n = 0; n < 8; n++) begin
				d = dot(ca[n][0], ca[n][1], ca[n][2], ax[s][0], ax[s][1], ax[s][2]);
				if (n == 0 || d < mna) mna = d;
				if (n == 0 || d > mxa) mxa = d;
				d = dot(cb[n][0], cb[n][1], cb[n][2], ax[s][0], ax[s][1], ax[s][2]);
				if (n == 0 || d < mnb) mnb = d;
				if (n == 0 || d > mxb) mxb = d;
			end
			sum  = (mxa - mna) + (mxb - mnb);
			span = ((mxa < mxb) ? mxb : mxa) - ((mnb < mna) ? mnb : mna);
			if (sum < span) ov = 0;
		end
		return ov;
	endfunction

	task automatic push(int s, logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z, bit l);
		load_t t;
		t.slot = 4'(s);
		t.x    = x;
		t.y    = y;
		t.z    = z;
		t.last = l;
		loads = {loads, t};
		n_loaded++;
	endtask

	function automatic logic signed [31:0] rq(int s);
		return $urandom_range(0, 2 * s) - s;
	endfunction

	task automatic rand_val(int s, int idx, bit wild, output logic signed [31:0] v);
		if (wild && $urandom_range(0, 3) == 0) v = $urandom;
		else if (idx == 4 || idx == 9) v = $urandom_range(0, 2 * ONE);
		else if (idx == 0 || idx == 5) v = rq(3 * ONE);
		else v = rq(s);
	endtask

	task automatic box_pair(bit twin, bit wild);
		int order[10];
		logic signed [31:0] x, y, z;
		logic signed [31:0] ax[3][3];
		for (int i = 0; i < 10; i++) order[i] = i;
		order.shuffle();
		for (int i = 0; i < 10; i++) begin
			rand_val(ONE, order[i], wild, x);
			rand_val(ONE, order[i], wild, y);
			rand_val(ONE, order[i], wild, z);
			if (twin && order[i] >= 1 && order[i] <= 3) begin
				ax[order[i] - 1][0] = x;
				ax[order[i] - 1][1] = y;
				ax[order[i] - 1][2] = z;
			end
			push(order[i], x, y, z, i == 9 && !twin);
		end
		if (twin)
			for (int i = 0; i < 3; i++)
				push(6 + i, ax[i][0], ax[i][1], ax[i][2], i == 2);
	endtask

	initial begin
		n_loaded = 0;
		arst_n   = 0;

		// identical unit boxes at the origin
		for (int b = 0; b < 2; b++) begin
			push(5 * b, 0, 0, 0, 0);
			push(5 * b + 1, ONE, 0, 0, 0);
			push(5 * b + 2, 0, ONE, 0, 0);
			push(5 * b + 3, 0, 0, ONE, 0);
			push(5 * b + 4, ONE, ONE, ONE, b == 1);
		end
		push(5, 2 * ONE, 0, 0, 1);
		push(5, 2 * ONE + 1, 0, 0, 1);
		push(6, 46341, 46341, 0, 0);
		push(7, -46341, 46341, 0, 1);
		push(5, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1);
		push(0, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 1);
		push(9, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1);
		push(4, 0, 0, 0, 1);
		push(12, 32'sh7fffffff, -1, 32'sh80000000, 1);
		push(15, -1, -1, -1, 0);
		push(10, 0, 0, 0, 1);

		while (n_loaded < N_ITEMS) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: box_pair(0, 0);
				6: box_pair(0, 1);
				7: box_pair(1, 0);
				8: begin
					int k;
					k = $urandom_range(1, 4);
					for (int i = 0; i < k; i++)
						push($urandom_range(0, 15), $urandom, $urandom, $urandom, 0);
				end
				default: begin
					int k;
					k = $urandom_range(1, 3);
					for (int i = 0; i < k; i++)
						push($urandom_range(0, 15), rq(2 * ONE), rq(2 * ONE), rq(2 * ONE),
							i == k - 1);
				end
			endcase
		end

		repeat (2) @(posedge clk);
		arst_n <= 1;
		do @(posedge clk); while (loads.size() != 0 || in_valid || hits_due.size() != 0);
		repeat (200) @(posedge clk);
		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			in_gap   <= 0;
			slot     <= '0;
			vx       <= '0;
			vy       <= '0;
			vz       <= '0;
			last     <= 0;
		end else if (!in_valid || in_ready) begin
			if (in_gap != 0) begin
				in_gap   <= in_gap - 1;
				in_valid <= 0;
			end else if (loads.size() != 0) begin
				cur = loads.pop_front();
				slot     <= cur.slot;
				vx       <= cur.x;
				vy       <= cur.y;
				vz       <= cur.z;
				last     <= cur.last;
				in_valid <= 1;
				if (loads.size() > CALM_LEFT && $urandom_range(0, 5) == 0)
					in_gap <= $urandom_range(1, 3);
			end else begin
				in_valid <= 0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 0;
			out_gap   <= 0;
		end else if (out_gap != 0) begin
			out_gap   <= out_gap - 1;
			out_ready <= 0;
		end else begin
			out_ready <= 1;
			if (loads.size() > CALM_LEFT && $urandom_range(0, 5) == 0)
				out_gap <= $urandom_range(1, 3);
		end
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			if (slot < 10) begin
				vec_mem[slot * 3]     = vx;
				vec_mem[slot * 3 + 1] = vy;
				vec_mem[slot * 3 + 2] = vz;
			end
			if (last) hits_due = {hits_due, boxes_overlap()};
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (hits_due.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result beat: hit=%0b", hit);
			end else begin
				bit want;
				want = hits_due.pop_front();
				if (hit !== want) begin
					errors++;
					if (errors <= 10) $display("hit mismatch: expected %0b, got %0b", want, hit);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

endmodule
